// File: sv/sdq_pkg.sv
// Shared types and constants of the symbol deque with pair counts.
// Holds the request and result payload layouts and the command codes.
// No dependencies; the block, the checker and the test import this package.
package sdq_pkg;

  localparam int DEF_MAX_LENGTH  = 1024;
  localparam int DEF_NUM_SYMBOLS = 8;

  localparam logic [2:0] CMD_FILL     = 3'd0;
  localparam logic [2:0] CMD_APP_BARB = 3'd1;
  localparam logic [2:0] CMD_APP_PNT  = 3'd2;
  localparam logic [2:0] CMD_POP_BARB = 3'd3;
  localparam logic [2:0] CMD_POP_PNT  = 3'd4;
  localparam logic [2:0] CMD_UPD_SYM  = 3'd5;
  localparam logic [2:0] CMD_UPD_PAIR = 3'd6;
  localparam logic [2:0] CMD_QUERY    = 3'd7;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  write_state;
    logic [2:0]  match_state;
    logic [2:0]  match_barbed_state;
    logic [9:0]  instance_req;
    logic [10:0] fill_length;
    logic [2:0]  query_state;
    logic [2:0]  query_pointed;
    logic [2:0]  query_barbed;
  } sdq_in_t;

  typedef struct packed {
    logic [2:0]  popped_state;
    logic        hit;
    logic        error;
    logic [10:0] length;
    logic [2:0]  pointed_end;
    logic [2:0]  barbed_end;
    logic [10:0] state_total;
    logic [9:0]  pair_total;
  } sdq_out_t;

endpackage

// File: sv/sdq_chan_if.sv
// Valid/ready channel carrying one request or result payload.
// The payload type is given per instance, normally a struct from sdq_pkg.
interface sdq_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: sv/symbol_deque_with_pair_counts.sv
// Double-ended store of small symbols with a count per symbol and a count per ordered
// adjacent pair. One request is handled at a time. An update scans the symbol memory one
// entry per cycle from the pointed end; a fill clears the pair-count memory one entry per
// cycle, then writes the symbols one per cycle. The result becomes valid in the same cycle
// as the next request can be taken. After reset a clearing pass over the count memories
// runs before the first request is taken. A finished result waits in an output register,
// so the next request is taken while the previous result is still unread.
// Depends on sdq_pkg and sdq_chan_if.
module symbol_deque_with_pair_counts import sdq_pkg::*; #(
  parameter int MAX_LENGTH  = DEF_MAX_LENGTH,
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS
) (
  input  logic       clk,
  input  logic       rst_n,
  sdq_chan_if.sink   in_req,
  sdq_chan_if.source out_res
);

  localparam int AW   = $clog2(MAX_LENGTH);
  localparam int CW   = $clog2(MAX_LENGTH + 1);
  localparam int PCW  = $clog2(MAX_LENGTH);
  localparam int SW   = $clog2(NUM_SYMBOLS);
  localparam int NP   = NUM_SYMBOLS * NUM_SYMBOLS;
  localparam int PAW  = $clog2(NP);

  // Sequencer states.
  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_FWR  = 4'd1;
  localparam logic [3:0] ST_FFIN = 4'd2;
  localparam logic [3:0] ST_IDLE = 4'd3;
  localparam logic [3:0] ST_SCAN = 4'd4;
  localparam logic [3:0] ST_G0   = 4'd5;
  localparam logic [3:0] ST_G1   = 4'd6;
  localparam logic [3:0] ST_G2   = 4'd7;
  localparam logic [3:0] ST_G3   = 4'd8;
  localparam logic [3:0] ST_A0   = 4'd9;
  localparam logic [3:0] ST_A1   = 4'd10;
  localparam logic [3:0] ST_O0   = 4'd11;
  localparam logic [3:0] ST_O1   = 4'd12;
  localparam logic [3:0] ST_O2   = 4'd13;

  // Reduce a 3-bit symbol code modulo the alphabet size by repeated subtraction.
  function automatic logic [SW-1:0] sym_mod(input logic [2:0] v);
    logic [6:0] r;
    r = 7'(v);
    for (int i = 0; i < 4; i++) begin
      if (r >= 7'(NUM_SYMBOLS)) begin
        r = r - 7'(NUM_SYMBOLS);
      end
    end
    return SW'(r);
  endfunction

  function automatic logic [PAW-1:0] pidx(input logic [SW-1:0] a, input logic [SW-1:0] b);
    return PAW'(PAW'(a) * PAW'(NUM_SYMBOLS)) + PAW'(b);
  endfunction

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    return (s == AW'(MAX_LENGTH - 1)) ? '0 : AW'(s + 1'b1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
    return (s == '0) ? AW'(MAX_LENGTH - 1) : AW'(s - 1'b1);
  endfunction

  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] h, input logic [CW-1:0] k);
    logic [AW:0] s;
    s = (AW+1)'(h) + (AW+1)'(k);
    if (s >= (AW+1)'(MAX_LENGTH)) begin
      s = s - (AW+1)'(MAX_LENGTH);
    end
    return AW'(s);
  endfunction

  // Memories: symbols in ring order, per-symbol counts, per-pair counts.
  logic [SW-1:0]  sym_mem  [MAX_LENGTH];
  logic [CW-1:0]  cnt_mem  [NUM_SYMBOLS];
  logic [PCW-1:0] pair_mem [NP];

  logic           sym_we, cnt_we, pair_we;
  logic [AW-1:0]  sym_wa, sym_ra;
  logic [SW-1:0]  sym_wd, cnt_wa, cnt_ra;
  logic [CW-1:0]  cnt_wd;
  logic [PAW-1:0] pair_wa, pair_ra;
  logic [PCW-1:0] pair_wd;
  logic [SW-1:0]  sym_rd_r;
  logic [CW-1:0]  cnt_rd_r;
  logic [PCW-1:0] pair_rd_r;

  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_mem[sym_wa] <= sym_wd;
    end
    sym_rd_r <= sym_mem[sym_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_r <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[pair_wa] <= pair_wd;
    end
    pair_rd_r <= pair_mem[pair_ra];
  end

  // Control registers.
  logic [3:0]     state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [PAW-1:0] ci_r, ci_nxt;
  logic           clr_fill_r, clr_fill_nxt;
  logic [CW-1:0]  len_r, len_nxt;
  logic [AW-1:0]  head_r, head_nxt;
  logic           pv_r, pv_nxt;

  // Request and working registers.
  logic [2:0]     cmd_r, cmd_nxt;
  logic [SW-1:0]  ns_r, ns_nxt, ms_r, ms_nxt, mb_r, mb_nxt, qs_r, qs_nxt;
  logic [PAW-1:0] qpa_r, qpa_nxt;
  logic [9:0]     inst_r, inst_nxt;
  logic [CW-1:0]  flen_r, flen_nxt, fk_r, fk_nxt;
  logic [AW-1:0]  kslot_r, kslot_nxt, ss_r, ss_nxt, ds_r, ds_nxt;
  logic [SW-1:0]  prv_r, prv_nxt, old_r, old_nxt, nxt_r, nxt_nxt, psym_r, psym_nxt;
  logic           has_p_r, has_p_nxt, has_n_r, has_n_nxt;
  logic           rem_r, rem_nxt, ins_r, ins_nxt;
  logic [1:0]     step_r, step_nxt;
  logic [CW-1:0]  sk_r, sk_nxt, dk_r, dk_nxt, seen_r, seen_nxt;
  logic [2:0]     popped_r, popped_nxt, pe_r, pe_nxt;
  logic           hit_r, hit_nxt, err_r, err_nxt;
  logic [CW-1:0]  stot_r, stot_nxt;
  logic [PCW-1:0] ptot_r, ptot_nxt;
  sdq_out_t       out_r, out_nxt;

  // Count adjustment for the current step. A removed symbol loses its count and the pairs
  // it formed with its neighbors; an inserted symbol gains them. Steps run one at a time so
  // that two adjustments of the same entry never overlap.
  logic [PAW-1:0] adj_pa;
  logic           adj_pdec, adj_pen;
  logic [SW-1:0]  adj_ca;
  logic           adj_cdec, adj_cen;

  always_comb begin
    adj_pa   = pidx(old_r, nxt_r);
    adj_pdec = 1'b1;
    adj_pen  = 1'b0;
    adj_ca   = old_r;
    adj_cdec = 1'b1;
    adj_cen  = 1'b0;
    unique case (step_r)
      2'd0: begin
        adj_pa  = pidx(old_r, nxt_r);
        adj_pen = rem_r & has_n_r;
        adj_ca  = old_r;
        adj_cen = rem_r;
      end
      2'd1: begin
        adj_pa   = pidx(ns_r, nxt_r);
        adj_pdec = 1'b0;
        adj_pen  = ins_r & has_n_r;
        adj_ca   = ns_r;
        adj_cdec = 1'b0;
        adj_cen  = ins_r;
      end
      2'd2: begin
        adj_pa  = pidx(prv_r, old_r);
        adj_pen = rem_r & has_p_r;
      end
      default: begin
        adj_pa   = pidx(prv_r, ns_r);
        adj_pdec = 1'b0;
        adj_pen  = ins_r & has_p_r;
      end
    endcase
  end

  sdq_in_t    req;
  logic [2:0] scan_sym;
  logic       scan_match;
  logic       scan_issue;

  assign req        = in_req.payload;
  assign in_req.ready = (state_r == ST_IDLE);
  assign out_res.valid   = out_valid_r;
  assign out_res.payload = out_r;

  // A stored symbol matches when it equals the searched symbol, or, for a pair search,
  // when it and the symbol before it form the searched pair.
  assign scan_sym   = 3'(sym_rd_r);
  assign scan_issue = (sk_r < len_r);
  assign scan_match = (cmd_r == CMD_UPD_SYM) ? (sym_rd_r == ms_r)
                    : ((dk_r != '0) && (psym_r == ms_r) && (sym_rd_r == mb_r));

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    ci_nxt        = ci_r;
    clr_fill_nxt  = clr_fill_r;
    len_nxt       = len_r;
    head_nxt      = head_r;
    pv_nxt        = pv_r;
    cmd_nxt       = cmd_r;
    ns_nxt        = ns_r;
    ms_nxt        = ms_r;
    mb_nxt        = mb_r;
    qs_nxt        = qs_r;
    qpa_nxt       = qpa_r;
    inst_nxt      = inst_r;
    flen_nxt      = flen_r;
    fk_nxt        = fk_r;
    kslot_nxt     = kslot_r;
    ss_nxt        = ss_r;
    ds_nxt        = ds_r;
    prv_nxt       = prv_r;
    old_nxt       = old_r;
    nxt_nxt       = nxt_r;
    psym_nxt      = psym_r;
    has_p_nxt     = has_p_r;
    has_n_nxt     = has_n_r;
    rem_nxt       = rem_r;
    ins_nxt       = ins_r;
    step_nxt      = step_r;
    sk_nxt        = sk_r;
    dk_nxt        = dk_r;
    seen_nxt      = seen_r;
    popped_nxt    = popped_r;
    pe_nxt        = pe_r;
    hit_nxt       = hit_r;
    err_nxt       = err_r;
    stot_nxt      = stot_r;
    ptot_nxt      = ptot_r;
    out_nxt       = out_r;

    sym_we  = 1'b0;
    sym_wa  = kslot_r;
    sym_wd  = ns_r;
    sym_ra  = kslot_r;
    cnt_we  = 1'b0;
    cnt_wa  = adj_ca;
    cnt_wd  = adj_cdec ? CW'(cnt_rd_r - 1'b1) : CW'(cnt_rd_r + 1'b1);
    cnt_ra  = adj_ca;
    pair_we = 1'b0;
    pair_wa = adj_pa;
    pair_wd = adj_pdec ? PCW'(pair_rd_r - 1'b1) : PCW'(pair_rd_r + 1'b1);
    pair_ra = adj_pa;

    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // Zero every pair count, and every symbol count on the way.
      ST_CLR: begin
        pair_we = 1'b1;
        pair_wa = ci_r;
        pair_wd = '0;
        if (32'(ci_r) < NUM_SYMBOLS) begin
          cnt_we = 1'b1;
          cnt_wa = SW'(ci_r);
          cnt_wd = '0;
        end
        ci_nxt = PAW'(ci_r + 1'b1);
        if (ci_r == PAW'(NP - 1)) begin
          ci_nxt = '0;
          fk_nxt = '0;
          state_nxt = clr_fill_r ? ST_FWR : ST_IDLE;
        end
      end

      ST_FWR: begin
        if (fk_r < flen_r) begin
          sym_we = 1'b1;
          sym_wa = AW'(fk_r);
          sym_wd = ns_r;
          fk_nxt = CW'(fk_r + 1'b1);
        end else begin
          state_nxt = ST_FFIN;
        end
      end

      // A run of n equal symbols holds n copies and n-1 pairs of that symbol with itself.
      ST_FFIN: begin
        head_nxt = '0;
        len_nxt  = flen_r;
        cnt_we   = 1'b1;
        cnt_wa   = ns_r;
        cnt_wd   = flen_r;
        pair_we  = (flen_r != '0);
        pair_wa  = pidx(ns_r, ns_r);
        pair_wd  = PCW'(flen_r - 1'b1);
        state_nxt = ST_O0;
      end

      ST_IDLE: begin
        if (in_req.valid) begin
          cmd_nxt    = req.command;
          ns_nxt     = sym_mod(req.write_state);
          ms_nxt     = sym_mod(req.match_state);
          mb_nxt     = sym_mod(req.match_barbed_state);
          inst_nxt   = req.instance_req;
          qs_nxt     = sym_mod(req.query_state);
          qpa_nxt    = pidx(sym_mod(req.query_pointed), sym_mod(req.query_barbed));
          popped_nxt = '0;
          hit_nxt    = 1'b0;
          err_nxt    = 1'b0;
          rem_nxt    = 1'b0;
          ins_nxt    = 1'b0;
          has_p_nxt  = 1'b0;
          has_n_nxt  = 1'b0;
          unique case (req.command)
            CMD_FILL: begin
              flen_nxt = (32'(req.fill_length) > MAX_LENGTH) ? CW'(MAX_LENGTH)
                                                             : CW'(req.fill_length);
              ci_nxt       = '0;
              clr_fill_nxt = 1'b1;
              state_nxt    = ST_CLR;
            end
            CMD_APP_BARB, CMD_APP_PNT: begin
              if (len_r == CW'(MAX_LENGTH)) begin
                err_nxt   = 1'b1;
                state_nxt = ST_O0;
              end else begin
                ins_nxt = 1'b1;
                if (req.command == CMD_APP_BARB) begin
                  has_p_nxt = (len_r != '0);
                  kslot_nxt = slot_add(head_r, len_r);
                end else begin
                  has_n_nxt = (len_r != '0);
                  kslot_nxt = slot_dec(head_r);
                end
                state_nxt = ST_G0;
              end
            end
            CMD_POP_BARB, CMD_POP_PNT: begin
              if (len_r == '0) begin
                err_nxt   = 1'b1;
                state_nxt = ST_O0;
              end else begin
                rem_nxt = 1'b1;
                if (req.command == CMD_POP_BARB) begin
                  has_p_nxt = (len_r > CW'(1));
                  kslot_nxt = slot_add(head_r, CW'(len_r - 1'b1));
                end else begin
                  has_n_nxt = (len_r > CW'(1));
                  kslot_nxt = head_r;
                end
                state_nxt = ST_G0;
              end
            end
            CMD_UPD_SYM, CMD_UPD_PAIR: begin
              sk_nxt    = '0;
              ss_nxt    = head_r;
              pv_nxt    = 1'b0;
              seen_nxt  = '0;
              state_nxt = ST_SCAN;
            end
            default: begin
              state_nxt = ST_O0;
            end
          endcase
        end
      end

      // One read issued per cycle; the data of the previous read is tested.
      ST_SCAN: begin
        sym_ra = ss_r;
        pv_nxt = scan_issue;
        if (scan_issue) begin
          ss_nxt = slot_inc(ss_r);
          ds_nxt = ss_r;
          dk_nxt = sk_r;
          sk_nxt = CW'(sk_r + 1'b1);
        end
        if (pv_r) begin
          psym_nxt = sym_rd_r;
          if (scan_match) begin
            if (32'(seen_r) == 32'(inst_r)) begin
              kslot_nxt = ds_r;
              rem_nxt   = 1'b1;
              ins_nxt   = 1'b1;
              has_p_nxt = (dk_r != '0);
              has_n_nxt = ((CW+1)'(dk_r) + 1'b1) < (CW+1)'(len_r);
              hit_nxt   = 1'b1;
              pv_nxt    = 1'b0;
              state_nxt = ST_G0;
            end else begin
              seen_nxt = CW'(seen_r + 1'b1);
            end
          end
        end else if (!scan_issue) begin
          state_nxt = ST_O0;
        end
      end

      // Read the neighbors and the symbol at the target slot.
      ST_G0: begin
        sym_ra    = slot_dec(kslot_r);
        state_nxt = ST_G1;
      end
      ST_G1: begin
        sym_ra    = kslot_r;
        prv_nxt   = sym_rd_r;
        state_nxt = ST_G2;
      end
      ST_G2: begin
        sym_ra    = slot_inc(kslot_r);
        old_nxt   = sym_rd_r;
        state_nxt = ST_G3;
      end
      ST_G3: begin
        nxt_nxt  = sym_rd_r;
        step_nxt = '0;
        sym_we   = ins_r;
        unique case (cmd_r)
          CMD_APP_BARB: begin
            len_nxt = CW'(len_r + 1'b1);
          end
          CMD_APP_PNT: begin
            len_nxt  = CW'(len_r + 1'b1);
            head_nxt = kslot_r;
          end
          CMD_POP_BARB: begin
            len_nxt    = CW'(len_r - 1'b1);
            popped_nxt = 3'(old_r);
          end
          CMD_POP_PNT: begin
            len_nxt    = CW'(len_r - 1'b1);
            head_nxt   = slot_inc(head_r);
            popped_nxt = 3'(old_r);
          end
          default: begin
          end
        endcase
        state_nxt = ST_A0;
      end

      ST_A0: begin
        state_nxt = ST_A1;
      end
      ST_A1: begin
        pair_we = adj_pen;
        cnt_we  = adj_cen;
        if (step_r == 2'd3) begin
          state_nxt = ST_O0;
        end else begin
          step_nxt  = 2'(step_r + 1'b1);
          state_nxt = ST_A0;
        end
      end

      // Read both ends and the queried counts as they stand after the request.
      ST_O0: begin
        sym_ra    = head_r;
        cnt_ra    = qs_r;
        pair_ra   = qpa_r;
        state_nxt = ST_O1;
      end
      ST_O1: begin
        sym_ra    = slot_add(head_r, CW'(len_r - 1'b1));
        pe_nxt    = (len_r != '0) ? scan_sym : '0;
        stot_nxt  = cnt_rd_r;
        ptot_nxt  = pair_rd_r;
        state_nxt = ST_O2;
      end
      ST_O2: begin
        sym_ra = slot_add(head_r, CW'(len_r - 1'b1));
        if (!out_valid_r || out_res.ready) begin
          out_nxt.popped_state = popped_r;
          out_nxt.hit          = hit_r;
          out_nxt.error        = err_r;
          out_nxt.length       = 11'(len_r);
          out_nxt.pointed_end  = pe_r;
          out_nxt.barbed_end   = (len_r != '0) ? scan_sym : '0;
          out_nxt.state_total  = 11'(stot_r);
          out_nxt.pair_total   = 10'(ptot_r);
          out_valid_nxt        = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
      ci_r        <= '0;
      clr_fill_r  <= 1'b0;
      len_r       <= '0;
      head_r      <= '0;
      pv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ci_r        <= ci_nxt;
      clr_fill_r  <= clr_fill_nxt;
      len_r       <= len_nxt;
      head_r      <= head_nxt;
      pv_r        <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    ns_r     <= ns_nxt;
    ms_r     <= ms_nxt;
    mb_r     <= mb_nxt;
    qs_r     <= qs_nxt;
    qpa_r    <= qpa_nxt;
    inst_r   <= inst_nxt;
    flen_r   <= flen_nxt;
    fk_r     <= fk_nxt;
    kslot_r  <= kslot_nxt;
    ss_r     <= ss_nxt;
    ds_r     <= ds_nxt;
    prv_r    <= prv_nxt;
    old_r    <= old_nxt;
    nxt_r    <= nxt_nxt;
    psym_r   <= psym_nxt;
    has_p_r  <= has_p_nxt;
    has_n_r  <= has_n_nxt;
    rem_r    <= rem_nxt;
    ins_r    <= ins_nxt;
    step_r   <= step_nxt;
    sk_r     <= sk_nxt;
    dk_r     <= dk_nxt;
    seen_r   <= seen_nxt;
    popped_r <= popped_nxt;
    pe_r     <= pe_nxt;
    hit_r    <= hit_nxt;
    err_r    <= err_nxt;
    stot_r   <= stot_nxt;
    ptot_r   <= ptot_nxt;
    out_r    <= out_nxt;
  end

`ifndef SYNTH
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CW'(MAX_LENGTH))
    else $error("held length beyond capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> (state_r != ST_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_hit_err_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.hit && out_r.error))
    else $error("result flags both hit and error");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready) |=> out_valid_r)
    else $error("pending result dropped");
`endif

endmodule

// File: dv/symbol_deque_with_pair_counts_checker.sv
// Checker for the symbol deque with pair counts: watches both channels, predicts each result.
// Depends on sdq_pkg.
`timescale 1ns / 100ps
module symbol_deque_with_pair_counts_checker import sdq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req_valid,
  input  logic       req_ready,
  input  sdq_in_t    req_payload,
  input  logic       res_valid,
  input  logic       res_ready,
  input  sdq_out_t   res_payload,
  output int         fail_count,
  output int         pending_count
);
  localparam int DEPTH = DEF_MAX_LENGTH;
  localparam int NSYM = DEF_NUM_SYMBOLS;
  // The block holds at most two requests, so a short ring of expected results is plenty.
  localparam int RING = 16;

  logic [2:0]  sym_mem [DEPTH];
  int unsigned head_ptr;
  int unsigned held;
  int unsigned sym_tally [NSYM];
  int unsigned pair_tally [NSYM*NSYM];
  sdq_out_t    expected_ring [RING];
  int unsigned put_cnt;
  int unsigned take_cnt;

  function automatic logic [2:0] peek(int unsigned k);
    return sym_mem[(head_ptr + k) % DEPTH];
  endfunction

  task automatic rewrite_at(int unsigned k, logic [2:0] ns);
    logic [2:0] old;
    old = peek(k);
    sym_tally[old]--;
    if (k + 1 < held) pair_tally[old*NSYM + peek(k+1)]--;
    if (k > 0) pair_tally[peek(k-1)*NSYM + old]--;
    sym_mem[(head_ptr + k) % DEPTH] = ns;
    sym_tally[ns]++;
    if (k + 1 < held) pair_tally[ns*NSYM + peek(k+1)]++;
    if (k > 0) pair_tally[peek(k-1)*NSYM + ns]++;
  endtask

  task automatic clear_model();
    head_ptr = 0;
    held = 0;
    foreach (sym_tally[i]) sym_tally[i] = 0;
    foreach (pair_tally[i]) pair_tally[i] = 0;
    put_cnt = 0;
    take_cnt = 0;
    fail_count = 0;
  endtask

  task automatic apply_request(sdq_in_t r);
    sdq_out_t o;
    int unsigned flen, seen;
    o = '0;
    seen = 0;
    case (r.command)
      CMD_FILL: begin
        flen = (r.fill_length > DEPTH) ? DEPTH : r.fill_length;
        head_ptr = 0;
        held = flen;
        foreach (sym_tally[i]) sym_tally[i] = 0;
        foreach (pair_tally[i]) pair_tally[i] = 0;
        for (int k = 0; k < held; k++) sym_mem[k] = r.write_state;
        sym_tally[r.write_state] = held;
        if (held > 0) pair_tally[r.write_state*NSYM + r.write_state] = held - 1;
      end
      CMD_APP_BARB: begin
        if (held >= DEPTH) o.error = 1'b1;
        else begin
          if (held > 0) pair_tally[peek(held-1)*NSYM + r.write_state]++;
          sym_mem[(head_ptr + held) % DEPTH] = r.write_state;
          held++;
          sym_tally[r.write_state]++;
        end
      end
      CMD_APP_PNT: begin
        if (held >= DEPTH) o.error = 1'b1;
        else begin
          if (held > 0) pair_tally[r.write_state*NSYM + peek(0)]++;
          head_ptr = (head_ptr + DEPTH - 1) % DEPTH;
          sym_mem[head_ptr] = r.write_state;
          held++;
          sym_tally[r.write_state]++;
        end
      end
      CMD_POP_BARB: begin
        if (held == 0) o.error = 1'b1;
        else begin
          o.popped_state = peek(held-1);
          if (held > 1) pair_tally[peek(held-2)*NSYM + o.popped_state]--;
          held--;
          sym_tally[o.popped_state]--;
        end
      end
      CMD_POP_PNT: begin
        if (held == 0) o.error = 1'b1;
        else begin
          o.popped_state = peek(0);
          if (held > 1) pair_tally[o.popped_state*NSYM + peek(1)]--;
          head_ptr = (head_ptr + 1) % DEPTH;
          held--;
          sym_tally[o.popped_state]--;
        end
      end
      CMD_UPD_SYM: begin
        for (int unsigned k = 0; k < held; k++) begin
          if (peek(k) == r.match_state) begin
            if (seen == r.instance_req) begin
              rewrite_at(k, r.write_state);
              o.hit = 1'b1;
              break;
            end
            seen++;
          end
        end
      end
      CMD_UPD_PAIR: begin
        for (int unsigned k = 1; k < held; k++) begin
          if (peek(k-1) == r.match_state && peek(k) == r.match_barbed_state) begin
            if (seen == r.instance_req) begin
              rewrite_at(k, r.write_state);
              o.hit = 1'b1;
              break;
            end
            seen++;
          end
        end
      end
      default: ;
    endcase
    o.length = 11'(held);
    o.pointed_end = held > 0 ? peek(0) : 3'd0;
    o.barbed_end = held > 0 ? peek(held-1) : 3'd0;
    o.state_total = 11'(sym_tally[r.query_state]);
    o.pair_total = 10'(pair_tally[r.query_pointed*NSYM + r.query_barbed]);
    expected_ring[put_cnt % RING] = o;
    put_cnt++;
  endtask

  task automatic report(string what, sdq_out_t got, sdq_out_t want);
    $display("mismatch (%s) at %0t: got %h expected %h", what, $realtime, got, want);
    fail_count++;
  endtask

  assign pending_count = int'(put_cnt - take_cnt);

  // Predict on the request edge first so a same-cycle result never sees a stale ring.
  always @(posedge clk) begin : monitor
    sdq_out_t w;
    if (!rst_n) begin
      clear_model();
    end else begin
      if (req_valid && req_ready) apply_request(req_payload);
      if (res_valid && res_ready) begin
        if (put_cnt == take_cnt) begin
          report("unexpected result", res_payload, '0);
        end else begin
          w = expected_ring[take_cnt % RING];
          take_cnt++;
          if (res_payload !== w) report("result fields", res_payload, w);
        end
      end
    end
  end
endmodule

// File: dv/symbol_deque_with_pair_counts_test.sv
// Top of the symbol deque regression: clock, reset, request stimulus, result stalls, verdict.
// Depends on sdq_pkg, sdq_chan_if, the block and symbol_deque_with_pair_counts_checker.
`timescale 1ns / 100ps
module symbol_deque_with_pair_counts_test;
  import sdq_pkg::*;

  // A long stretch with no handshake on either channel means the block has hung.
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 560;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   sent_count;
  int   idle_cycles;
  int   fills_sent;

  sdq_chan_if #(.payload_t(sdq_in_t))  req_ch ();
  sdq_chan_if #(.payload_t(sdq_out_t)) res_ch ();

  symbol_deque_with_pair_counts DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch.sink),
    .out_res (res_ch.source)
  );

  symbol_deque_with_pair_counts_checker checker_inst (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_ch.valid),
    .req_ready     (req_ch.ready),
    .req_payload   (req_ch.payload),
    .res_valid     (res_ch.valid),
    .res_ready     (res_ch.ready),
    .res_payload   (res_ch.payload),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls on its own pattern; once, it holds off for a long stretch so that
  // the result register fills and the block refuses further requests.
  initial begin
    int mode;
    bit hold_done;
    hold_done = 1'b0;
    res_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (!hold_done && sent_count > 200) begin
        hold_done = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      mode = $urandom_range(0, 9);
      if (mode == 9) begin
        // A stretch of steady ready with no stall.
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(5, 40)) @(posedge clk);
      end else begin
        res_ch.ready <= (mode >= 3);
      end
    end
  end

  // The watchdog resets on any handshake on either channel.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("symbol_deque_with_pair_counts regression: fail");
      $finish;
    end
  end

  // Offers one request and holds it until the block takes it.
  task automatic send_request(sdq_in_t r);
    req_ch.valid <= 1'b1;
    req_ch.payload <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_count++;
    if (r.command == CMD_FILL) fills_sent++;
  endtask

  task automatic idle_sender(int cycles);
    req_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic sdq_in_t random_fields();
    sdq_in_t r;
    r = '0;
    r.command = 3'($urandom_range(0, 7));
    r.write_state = 3'($urandom_range(0, 7));
    r.match_state = 3'($urandom_range(0, 7));
    r.match_barbed_state = 3'($urandom_range(0, 7));
    r.instance_req = ($urandom_range(0, 15) == 0) ? 10'($urandom) : 10'($urandom_range(0, 6));
    r.fill_length = 11'($urandom_range(0, 24));
    r.query_state = 3'($urandom_range(0, 7));
    r.query_pointed = 3'($urandom_range(0, 7));
    r.query_barbed = 3'($urandom_range(0, 7));
    return r;
  endfunction

  function automatic sdq_in_t make_cmd(logic [2:0] op, logic [2:0] ns, logic [10:0] flen);
    sdq_in_t r;
    r = random_fields();
    r.command = op;
    r.write_state = ns;
    r.fill_length = flen;
    return r;
  endfunction

  initial begin
    sdq_in_t r;
    int burst;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    sent_count = 0;
    fills_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: pops on an empty store, append on empty, every command, a fill of
    // zero, an oversized fill that saturates, appends on a full store, and the last pop.
    send_request(make_cmd(CMD_POP_BARB, 3'd0, 11'd0));
    send_request(make_cmd(CMD_POP_PNT, 3'd0, 11'd0));
    send_request(make_cmd(CMD_APP_BARB, 3'd7, 11'd0));
    send_request(make_cmd(CMD_POP_PNT, 3'd0, 11'd0));
    send_request(make_cmd(CMD_APP_PNT, 3'd3, 11'd0));
    send_request(make_cmd(CMD_APP_BARB, 3'd3, 11'd0));
    send_request(make_cmd(CMD_APP_BARB, 3'd5, 11'd0));
    r = make_cmd(CMD_UPD_PAIR, 3'd6, 11'd0);
    r.match_state = 3'd3; r.match_barbed_state = 3'd3; r.instance_req = 10'd0;
    send_request(r);
    r = make_cmd(CMD_UPD_SYM, 3'd0, 11'd0);
    r.match_state = 3'd5; r.instance_req = 10'd0;
    send_request(r);
    r.instance_req = 10'd1023;
    send_request(r);
    send_request(make_cmd(CMD_QUERY, 3'd0, 11'd0));
    send_request(make_cmd(CMD_FILL, 3'd2, 11'd0));
    send_request(make_cmd(CMD_POP_BARB, 3'd0, 11'd0));
    send_request(make_cmd(CMD_FILL, 3'd7, 11'd5));
    // Overlapping pair matches in a run of equal symbols: the third match is rewritten.
    r = make_cmd(CMD_UPD_PAIR, 3'd1, 11'd0);
    r.match_state = 3'd7; r.match_barbed_state = 3'd7; r.instance_req = 10'd2;
    send_request(r);
    send_request(make_cmd(CMD_FILL, 3'd4, 11'd2047));
    send_request(make_cmd(CMD_APP_BARB, 3'd1, 11'd0));
    send_request(make_cmd(CMD_APP_PNT, 3'd1, 11'd0));
    r = make_cmd(CMD_UPD_SYM, 3'd6, 11'd0);
    r.match_state = 3'd4; r.instance_req = 10'd1023;
    send_request(r);
    send_request(make_cmd(CMD_POP_PNT, 3'd0, 11'd0));
    send_request(make_cmd(CMD_FILL, 3'd1, 11'd1));
    send_request(make_cmd(CMD_POP_BARB, 3'd0, 11'd0));
    r = '1;
    r.command = CMD_QUERY;
    send_request(r);

    // Pause until every expected result has come in; wait for an edge first so that the last
    // request is already predicted.
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);

    // Random part: mostly short stores built by appends, with random gaps and bursts.
    while (sent_count < RANDOM_ITEMS + 23) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        r = random_fields();
        // Keep appends and updates frequent so the store stays populated.
        case ($urandom_range(0, 9))
          0, 1, 2: r.command = ($urandom_range(0, 1)) ? CMD_APP_BARB : CMD_APP_PNT;
          3: r.command = ($urandom_range(0, 1)) ? CMD_UPD_SYM : CMD_UPD_PAIR;
          default: ;
        endcase
        if (r.command == CMD_FILL && $urandom_range(0, 40) == 0)
          r.fill_length = 11'($urandom_range(1000, 2047));
        if (r.command == CMD_FILL && $urandom_range(0, 60) == 0) r.fill_length = 11'($urandom);
        send_request(r);
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 30));
    end
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d requests including %0d fills, empty and full stores,",
             sent_count, fills_sent);
    $display("overlapping pair updates, and long result stalls");
    if (fail_count == 0) begin
      $display("symbol_deque_with_pair_counts regression: pass");
    end else begin
      $display("symbol_deque_with_pair_counts regression: fail");
    end
    $finish;
  end
endmodule
